// File: hdl/hsfi_pkg.sv
// shared types, constants and helpers for the hash slot find-or-insert unit
package hsfi_pkg;

  localparam int INDEX_BITS = 10;
  localparam int TABLE_SIZE = 1 << INDEX_BITS;
  localparam int KEY_W      = 64;
  localparam int SLOT_W     = 10;
  localparam int STATUS_W   = 3;
  localparam int STEP_SHIFT = 60;
  localparam int STEP_W     = KEY_W - STEP_SHIFT;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [STEP_W-1:0]     step_t;
  typedef logic [SLOT_W-1:0]     slot_t;

  localparam idx_t IDX_MAX = {INDEX_BITS{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_ZERO_KEY = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic {
    OP_FIND_INSERT = 1'b0,
    OP_CLEAR       = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_DONE
  } seq_state_t;

  // one request to the slot store: a write port and a read port
  typedef struct packed {
    logic we;
    idx_t waddr;
    key_t wdata;
    logic re;
    idx_t raddr;
  } ram_req_t;

  typedef struct packed {
    slot_t   slot;
    status_t status;
  } result_t;

  // probe step: top bits of the key forced odd
  function automatic step_t key_step(input key_t key);
    return key[KEY_W-1:STEP_SHIFT] | step_t'(1);
  endfunction

  function automatic idx_t idx_add(input idx_t idx, input step_t step);
    return idx + idx_t'(step);
  endfunction

endpackage

// File: hdl/hsfi_slot_store.sv
// key store: one slot per entry, one write and one registered read per cycle
module hsfi_slot_store (
  input  logic              clk,
  input  hsfi_pkg::ram_req_t req,
  output hsfi_pkg::key_t     rd_data
);
  import hsfi_pkg::*;

  key_t mem [TABLE_SIZE];
  key_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/hsfi_probe_seq.sv
// probe sequencer: clearing sweep, probe loop with the key compare and index adder
module hsfi_probe_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_op,
  input  hsfi_pkg::key_t       in_key,
  output logic                 in_ready,
  input  hsfi_pkg::key_t       rd_data,
  output hsfi_pkg::ram_req_t   ram_req,
  output logic                 res_valid,
  input  logic                 res_ready,
  output hsfi_pkg::result_t    res,
  output hsfi_pkg::seq_state_t state
);
  import hsfi_pkg::*;

  seq_state_t state_r, state_nxt;
  idx_t       clr_cnt_r, clr_cnt_nxt;
  logic       report_r, report_nxt;
  idx_t       n_r, n_nxt;
  idx_t       idx_r, idx_nxt;
  key_t       key_r, key_nxt;
  step_t      step_r, step_nxt;
  result_t    res_r, res_nxt;

  logic  accept;
  logic  hit;
  logic  empty;
  idx_t  start_idx;
  idx_t  next_idx;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign hit       = (rd_data == key_r);
  assign empty     = (rd_data == '0);
  assign start_idx = idx_add(in_key[INDEX_BITS-1:0], key_step(in_key));
  assign next_idx  = idx_add(idx_r, step_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == IDX_MAX) begin
          state_nxt = report_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_CLEAR) begin
            state_nxt = S_CLEAR;
          end else if (in_key == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (hit || empty || (n_r == IDX_MAX)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and store requests
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    res_valid     = (state_r == S_DONE);
    ram_req.we    = 1'b0;
    ram_req.waddr = idx_r;
    ram_req.wdata = key_r;
    ram_req.re    = 1'b0;
    ram_req.raddr = start_idx;
    case (state_r)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_cnt_r;
        ram_req.wdata = '0;
      end
      S_IDLE: begin
        ram_req.re = accept;
      end
      S_PROBE: begin
        // claim the first empty slot unless the key is already there
        ram_req.we    = empty && !hit;
        // next probe is read ahead; it is ignored if this one resolves
        ram_req.re    = 1'b1;
        ram_req.raddr = next_idx;
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    report_nxt  = report_r;
    n_nxt       = n_r;
    idx_nxt     = idx_r;
    key_nxt     = key_r;
    step_nxt    = step_r;
    res_nxt     = res_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + idx_t'(1);
        if (clr_cnt_r == IDX_MAX) begin
          report_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          key_nxt     = in_key;
          step_nxt    = key_step(in_key);
          idx_nxt     = start_idx;
          n_nxt       = '0;
          clr_cnt_nxt = '0;
          res_nxt     = '{slot: '0, status: ST_ZERO_KEY};
          if (in_op == OP_CLEAR) begin
            report_nxt = 1'b1;
            res_nxt    = '{slot: '0, status: ST_CLEARED};
          end
        end
      end
      S_PROBE: begin
        if (hit) begin
          res_nxt = '{slot: slot_t'(idx_r), status: ST_FOUND};
        end else if (empty) begin
          res_nxt = '{slot: slot_t'(idx_r), status: ST_INSERTED};
        end else if (n_r == IDX_MAX) begin
          res_nxt = '{slot: '0, status: ST_FULL};
        end else begin
          idx_nxt = next_idx;
          n_nxt   = n_r + idx_t'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      report_r  <= 1'b0;
      n_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      report_r  <= report_nxt;
      n_r       <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    key_r  <= key_nxt;
    step_r <= step_nxt;
    res_r  <= res_nxt;
  end

  assign res   = res_r;
  assign state = state_r;

endmodule

// File: hdl/hash_slot_find_or_insert_unit.sv
// top level of the hash slot find-or-insert unit
// Open-addressed table of 2^INDEX_BITS 64-bit keys (zero = empty slot), probed with
// double hashing: step = key[63:60] | 1, first slot (key + step) mod size. A
// find-or-insert request is accepted, then probes one slot after another while the
// single store read port returns the next slot, then hands its result to the output
// register. Zero keys are answered without probing. A clear request, and reset,
// sweep the store one slot per cycle over all 2^INDEX_BITS slots (1024 at the
// default size), during which no request is accepted; the sweep after reset gives
// no result.
module hash_slot_find_or_insert_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hsfi_pkg::IN_DATA_W-1:0]    in_tdata,   // [63:0] key
  input  logic                              in_tuser,   // [0] op
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hsfi_pkg::OUT_DATA_W-1:0]   out_tdata,  // [9:0] slot, [15:10] zero
  output logic [hsfi_pkg::STATUS_W-1:0]     out_tuser   // [2:0] status
);
  import hsfi_pkg::*;

  ram_req_t   ram_req;
  key_t       rd_data;
  logic       res_valid;
  logic       res_ready;
  result_t    res;
  seq_state_t seq_state;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;

  hsfi_probe_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_key    (in_tdata),
    .in_ready  (in_tready),
    .rd_data   (rd_data),
    .ram_req   (ram_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .state     (seq_state)
  );

  hsfi_slot_store u_store (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // output register: takes a new result when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r.slot);
  assign out_tuser  = out_res_r.status;

  // results without a slot carry slot zero
  a_noslot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_ZERO_KEY ||
                   out_tuser == ST_CLEARED) |-> out_tdata == '0)
    else $error("slot not zero on a slotless result");

  // the store is only written by the clearing sweep or a claiming probe
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (seq_state == S_CLEAR || seq_state == S_PROBE))
    else $error("store written outside sweep or probe");

  // an accepted request leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> seq_state != S_IDLE && !in_tready)
    else $error("still idle after accepting a request");

  // a result is only offered after it was loaded from the sequencer
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(res_valid))
    else $error("output valid without a finished request");

endmodule
